FILE: rtl/core/rcp_pkg.sv
package rcp_pkg;

  // Buffer and argument table sizes
  localparam int BUF_LEN  = 256;
  localparam int ARGV_LEN = 8;

  // Field widths
  localparam int POS_W  = 9;   // write position, can reach BUF_LEN
  localparam int ADDR_W = 8;   // buffer address
  localparam int IDX_W  = 4;   // argument index
  localparam int CNT_W  = 17;  // signed length / count accumulators

  // Event codes
  localparam logic [2:0] EV_NONE     = 3'd0;
  localparam logic [2:0] EV_READY    = 3'd1;
  localparam logic [2:0] EV_SYNTAX   = 3'd2;
  localparam logic [2:0] EV_OVERFLOW = 3'd3;
  localparam logic [2:0] EV_ARGC     = 3'd4;

  // One result item
  typedef struct packed {
    logic [2:0]        event_res;
    logic [7:0]        arg_count;
    logic              wr_a_valid;
    logic [ADDR_W-1:0] wr_a_addr;
    logic [7:0]        wr_a_data;
    logic              wr_b_valid;
    logic [ADDR_W-1:0] wr_b_addr;
    logic [7:0]        wr_b_data;
    logic              arg_start_valid;
    logic [IDX_W-1:0]  arg_index;
    logic [POS_W-1:0]  arg_start_pos;
  } rcp_res_t;

endpackage

FILE: rtl/core/rcp_parse.sv
// Parser state and per-byte decision logic. State advances on step.
module rcp_parse (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        rx_byte,
  output rcp_pkg::rcp_res_t res
);

  // Parser modes
  localparam logic [3:0] M_IDLE   = 4'd0;
  localparam logic [3:0] M_WORD   = 4'd1;
  localparam logic [3:0] M_QUOTE  = 4'd2;
  localparam logic [3:0] M_DOT    = 4'd3;
  localparam logic [3:0] M_DOLLAR = 4'd4;
  localparam logic [3:0] M_STAR   = 4'd5;
  localparam logic [3:0] M_LINE   = 4'd6;
  localparam logic [3:0] M_BIN    = 4'd7;
  localparam logic [3:0] M_CR     = 4'd8;
  localparam logic [3:0] M_LF     = 4'd9;
  localparam logic [3:0] M_NEXT   = 4'd10;

  // Characters
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  localparam int CW = rcp_pkg::CNT_W;
  localparam int PW = rcp_pkg::POS_W;
  localparam logic signed [CW-1:0] CNT_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [CW-1:0] CNT_SAT = CW'(65535);
  localparam logic [PW-1:0] BUF_END  = PW'(rcp_pkg::BUF_LEN);
  localparam logic [7:0]    ARGV_MAX = 8'(rcp_pkg::ARGV_LEN);

  // Decimal accumulate with saturation at 65535; acc is never negative here
  function automatic logic signed [CW-1:0] accum(logic signed [CW-1:0] acc,
                                                 logic [7:0] c);
    logic [CW+3:0] a;
    logic [CW+3:0] v;
    a = {4'b0, acc};
    v = (a << 3) + (a << 1) + {{(CW){1'b0}}, c[3:0]};
    return (v > {4'b0, CNT_SAT}) ? CNT_SAT : v[CW-1:0];
  endfunction

  logic [3:0]           parse_mode, parse_mode_next;
  logic [PW-1:0]        write_pos, write_pos_next;
  logic [7:0]           arg_counter, arg_counter_next;
  logic signed [CW-1:0] args_remaining, args_remaining_next;
  logic signed [CW-1:0] chars_remaining, chars_remaining_next;
  logic [PW-1:0]        cur_arg_start, cur_arg_start_next;

  // Per-byte decision, written in the order the byte is processed
  always_comb begin : decide
    logic [3:0]           md;
    logic [PW-1:0]        wp;
    logic [7:0]           ac;
    logic signed [CW-1:0] ar;
    logic signed [CW-1:0] cr;
    logic [PW-1:0]        cs;
    logic [7:0]           c;
    logic                 skip;
    logic                 clr;
    logic                 is_digit;
    rcp_pkg::rcp_res_t    r;

    md   = parse_mode;
    wp   = write_pos;
    ac   = arg_counter;
    ar   = args_remaining;
    cr   = chars_remaining;
    cs   = cur_arg_start;
    c    = rx_byte;
    skip = 1'b0;
    clr  = 1'b0;
    r    = '0;
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);

    // Start of a request or of the next binary element
    if (md == M_IDLE || md == M_NEXT) begin
      if (c == CH_PLUS || c == CH_MINUS || c == CH_COLON) begin
        cr = '0; md = M_LINE; skip = 1'b1;
      end else if (c == CH_STAR && md == M_IDLE) begin
        cr = -CW'(1); ar = '0; md = M_STAR; skip = 1'b1;
      end else if (c == CH_DOLLAR) begin
        cr = '0; md = M_DOLLAR; skip = 1'b1;
      end else if (md == M_NEXT) begin
        clr = 1'b1; r.event_res = rcp_pkg::EV_SYNTAX; skip = 1'b1;
      end else if (c == CH_CR || c == CH_LF) begin
        skip = 1'b1;
      end else begin
        md = M_WORD;
      end
    end

    if (!skip) begin
      unique case (md)
        M_LINE: begin
          if (c == CH_CR) md = M_LF;
          if (wp < BUF_END) begin
            r.wr_a_valid = 1'b1; r.wr_a_addr = wp[7:0];
            r.wr_a_data = (c == CH_CR) ? 8'h00 : c; wp = wp + 1'b1;
          end
        end
        M_BIN: begin
          if (wp < BUF_END) begin
            r.wr_a_valid = 1'b1; r.wr_a_addr = wp[7:0]; r.wr_a_data = c;
            wp = wp + 1'b1;
          end
          cr = cr - CW'(1);
          if (!(cr > 0)) begin
            md = M_CR;
            if (wp < BUF_END) begin
              r.wr_b_valid = 1'b1; r.wr_b_addr = wp[7:0]; r.wr_b_data = 8'h00;
              wp = wp + 1'b1;
            end
          end
        end
        M_CR: begin
          if (c != CH_CR) begin
            clr = 1'b1; r.event_res = rcp_pkg::EV_SYNTAX;
          end else begin
            md = M_LF;
          end
        end
        M_LF: begin
          if (c != CH_LF) begin
            clr = 1'b1; r.event_res = rcp_pkg::EV_SYNTAX;
          end else if (cr > 0) begin
            md = M_BIN;
          end else begin
            md = M_NEXT;
            if (cr == '0) begin
              if (ac != 8'hFF) ac = ac + 8'd1;
              cs = wp;
              if (ac <= ARGV_MAX) begin
                r.arg_start_valid = 1'b1; r.arg_index = ac[3:0]; r.arg_start_pos = wp;
              end
              if (ar != CNT_MIN) ar = ar - CW'(1);
              // Last element of the array
              if (ar == '0) begin
                if (wp >= BUF_END) begin
                  r.event_res = rcp_pkg::EV_OVERFLOW;
                end else begin
                  r.event_res = rcp_pkg::EV_READY; r.arg_count = ac;
                end
                clr = 1'b1;
              end
            end
          end
        end
        M_STAR: begin
          if (c == CH_CR) md = M_LF;
          else if (!is_digit) begin
            clr = 1'b1; r.event_res = rcp_pkg::EV_SYNTAX;
          end else ar = accum(ar, c);
        end
        M_DOLLAR: begin
          if (c == CH_CR) md = M_LF;
          else if (c == CH_MINUS && cr == '0) cr = -CW'(1);
          else if (!is_digit) begin
            clr = 1'b1; r.event_res = rcp_pkg::EV_SYNTAX;
          end else if (cr != -CW'(1)) cr = accum(cr, c);
        end
        M_WORD, M_QUOTE, M_DOT: begin
          // Human text line
          if (c == CH_CR || c == CH_LF) begin
            if (wp == '0) begin
              clr = 1'b1;
            end else begin
              if (md == M_DOT || cs != wp) begin
                if (ac != 8'hFF) ac = ac + 8'd1;
              end else begin
                wp = wp - 1'b1;
              end
              if (ac > ARGV_MAX) begin
                r.event_res = rcp_pkg::EV_ARGC;
              end else if (wp >= BUF_END) begin
                r.event_res = rcp_pkg::EV_OVERFLOW;
              end else begin
                r.wr_a_valid = 1'b1; r.wr_a_addr = wp[7:0]; r.wr_a_data = 8'h00;
                wp = wp + 1'b1;
                cs = wp;
                if (ac <= ARGV_MAX) begin
                  r.arg_start_valid = 1'b1; r.arg_index = ac[3:0]; r.arg_start_pos = wp;
                end
                r.event_res = rcp_pkg::EV_READY;
                r.arg_count = ac;
              end
              clr = 1'b1;
            end
          end else if (c == CH_QUOTE && md == M_WORD && cs == wp) begin
            md = M_QUOTE;
          end else if (c == CH_QUOTE && md == M_QUOTE) begin
            md = M_DOT;
          end else if (c == CH_SPACE && md != M_QUOTE) begin
            // Word break; repeated spaces are dropped
            if (md == M_DOT || cs != wp) begin
              md = M_WORD;
              if (wp < BUF_END) begin
                r.wr_a_valid = 1'b1; r.wr_a_addr = wp[7:0]; r.wr_a_data = 8'h00;
                wp = wp + 1'b1;
              end
              if (ac != 8'hFF) ac = ac + 8'd1;
              cs = wp;
              if (ac <= ARGV_MAX) begin
                r.arg_start_valid = 1'b1; r.arg_index = ac[3:0]; r.arg_start_pos = wp;
              end
            end
          end else if (md == M_DOT) begin
            // Closing quote not followed by a space or line end: it was literal after all
            md = M_QUOTE;
            if (wp < BUF_END) begin
              r.wr_a_valid = 1'b1; r.wr_a_addr = wp[7:0]; r.wr_a_data = CH_QUOTE;
              wp = wp + 1'b1;
            end
            if (wp < BUF_END) begin
              r.wr_b_valid = 1'b1; r.wr_b_addr = wp[7:0]; r.wr_b_data = c;
              wp = wp + 1'b1;
            end
          end else begin
            if (wp < BUF_END) begin
              r.wr_a_valid = 1'b1; r.wr_a_addr = wp[7:0]; r.wr_a_data = c;
              wp = wp + 1'b1;
            end
          end
        end
        default: clr = 1'b1;
      endcase
    end

    // Soft reset after an event, an empty line or a bad mode; chars_remaining is kept
    if (clr) begin
      md = M_IDLE;
      wp = '0;
      ac = '0;
      cs = '0;
      ar = CW'(1);
    end

    parse_mode_next      = md;
    write_pos_next       = wp;
    arg_counter_next     = ac;
    args_remaining_next  = ar;
    chars_remaining_next = cr;
    cur_arg_start_next   = cs;
    res                  = r;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_mode      <= M_IDLE;
      write_pos       <= '0;
      arg_counter     <= '0;
      args_remaining  <= CW'(1);
      chars_remaining <= '0;
      cur_arg_start   <= '0;
    end else if (step) begin
      parse_mode      <= parse_mode_next;
      write_pos       <= write_pos_next;
      arg_counter     <= arg_counter_next;
      args_remaining  <= args_remaining_next;
      chars_remaining <= chars_remaining_next;
      cur_arg_start   <= cur_arg_start_next;
    end
  end

endmodule

FILE: rtl/core/resp_command_parser.sv
// Each byte passes through the input register, then the result register.
// Throughput: one byte per cycle unless out_stall holds the result; each byte gives exactly one result item.
// The only back-pressure is out_stall, passed to in_stall when both registers are full.
// Reset (rst, synchronous): parser returns to idle, write position and counts cleared (args_remaining set to 1),
// both pipeline registers emptied.
module resp_command_parser (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [7:0]                   rx_byte,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [2:0]                   event_res,
  output logic [7:0]                   arg_count,
  output logic                         wr_a_valid,
  output logic [rcp_pkg::ADDR_W-1:0]   wr_a_addr,
  output logic [7:0]                   wr_a_data,
  output logic                         wr_b_valid,
  output logic [rcp_pkg::ADDR_W-1:0]   wr_b_addr,
  output logic [7:0]                   wr_b_data,
  output logic                         arg_start_valid,
  output logic [rcp_pkg::IDX_W-1:0]    arg_index,
  output logic [rcp_pkg::POS_W-1:0]    arg_start_pos
);

  logic              in_full;
  logic [7:0]        in_byte;
  logic              advance;
  logic              accept_in;
  rcp_pkg::rcp_res_t res_comb;
  rcp_pkg::rcp_res_t out_res;

  // Move the held byte into the result register when it is free
  assign advance   = in_full && (!out_valid || !out_stall);
  assign in_stall  = in_full && !advance;
  assign accept_in = in_valid && !in_stall;

  rcp_parse u_parse (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .rx_byte (in_byte),
    .res     (res_comb)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (accept_in) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept_in) begin
      in_byte <= rx_byte;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res_comb;
    end
  end

  assign event_res       = out_res.event_res;
  assign arg_count       = out_res.arg_count;
  assign wr_a_valid      = out_res.wr_a_valid;
  assign wr_a_addr       = out_res.wr_a_addr;
  assign wr_a_data       = out_res.wr_a_data;
  assign wr_b_valid      = out_res.wr_b_valid;
  assign wr_b_addr       = out_res.wr_b_addr;
  assign wr_b_data       = out_res.wr_b_data;
  assign arg_start_valid = out_res.arg_start_valid;
  assign arg_index       = out_res.arg_index;
  assign arg_start_pos   = out_res.arg_start_pos;

  // Checks
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (in_full && out_valid && out_stall))
    else $error("input stalled without a blocked result");

  a_second_write: assert property (@(posedge clk) disable iff (rst)
    (out_valid && wr_b_valid) |->
      (wr_a_valid && wr_b_addr == 8'(wr_a_addr + 8'd1)))
    else $error("second write not right after first write");

  a_event_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (event_res <= rcp_pkg::EV_ARGC))
    else $error("event code out of range");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && arg_start_valid) |->
      ({4'b0, arg_index} <= 8'(rcp_pkg::ARGV_LEN)))
    else $error("pointer record beyond argument table");

endmodule
